>>> rtl/morse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// morse_pkg
// Shared types, code table and lookup functions of the Morse codec.
// ----------------------------------------------------------------------------
package morse_pkg;

  localparam int TABLE_ENTRIES = 36;
  localparam int MAX_SYMBOLS   = 5;
  localparam int CODE_COUNT    = 36;
  localparam int PATTERN_BITS  = 5;
  localparam int SEARCH_LIMIT  = (TABLE_ENTRIES < CODE_COUNT) ? TABLE_ENTRIES : CODE_COUNT;

  localparam logic       CMD_ENCODE = 1'b0;
  localparam logic       CMD_DECODE = 1'b1;

  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  typedef logic [PATTERN_BITS-1:0] pattern_t;
  typedef logic [2:0]              count_t;

  typedef struct packed {
    pattern_t pattern;
    count_t   count;
    logic     invalid;
  } tok_state_t;

  localparam int STATE_W = $bits(tok_state_t);

  typedef struct packed {
    logic       hit;
    logic [7:0] ch;
    pattern_t   pattern;
    count_t     len;
  } code_t;

  // bit i of a pattern is symbol i, set for a dash
  localparam logic [7:0] CODE_CHAR [CODE_COUNT] = '{
    8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
    8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
    8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A,
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39
  };

  localparam pattern_t CODE_PAT [CODE_COUNT] = '{
    5'd2,  5'd1,  5'd5,  5'd1,  5'd0,  5'd4,  5'd3,  5'd0,  5'd0,  5'd14,
    5'd5,  5'd2,  5'd3,  5'd1,  5'd7,  5'd6,  5'd11, 5'd2,  5'd0,  5'd1,
    5'd4,  5'd8,  5'd6,  5'd9,  5'd13, 5'd3,
    5'd31, 5'd30, 5'd28, 5'd24, 5'd16, 5'd0,  5'd1,  5'd3,  5'd7,  5'd15
  };

  localparam count_t CODE_LEN [CODE_COUNT] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
    3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
    3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  // text character to code, last matching entry wins
  function automatic code_t enc_lookup(input logic [7:0] c);
    code_t r;
    r = '0;
    for (int e = 0; e < SEARCH_LIMIT; e++) begin
      if (CODE_CHAR[e] == c) begin
        r.hit     = 1'b1;
        r.ch      = CODE_CHAR[e];
        r.pattern = CODE_PAT[e];
        r.len     = CODE_LEN[e];
      end
    end
    return r;
  endfunction

  // symbol pattern to code, last matching entry wins
  function automatic code_t dec_lookup(input pattern_t p, input count_t n);
    code_t r;
    r = '0;
    for (int e = 0; e < SEARCH_LIMIT; e++) begin
      if (CODE_LEN[e] == n && CODE_PAT[e] == p) begin
        r.hit     = 1'b1;
        r.ch      = CODE_CHAR[e];
        r.pattern = CODE_PAT[e];
        r.len     = CODE_LEN[e];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/morse_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// morse_if
// Valid/ready channels of the Morse codec: input items and result items.
// ----------------------------------------------------------------------------
interface morse_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] char_in;
  logic       end_of_message;

  modport source (output valid, command, char_in, end_of_message, input ready);
  modport sink   (input valid, command, char_in, end_of_message, output ready);
endinterface

interface morse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last_of_run;

  modport source (output valid, char_out, last_of_run, input ready);
  modport sink   (input valid, char_out, last_of_run, output ready);
endinterface
`default_nettype wire

>>> rtl/morse_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// morse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module morse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/morse_encode_decode_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// morse_encode_decode_unit
// International Morse codec: encodes text to dots and dashes, decodes tokens.
// ----------------------------------------------------------------------------
// in_ch carries one ASCII character per transaction with a command bit
// (encode or decode) and an end-of-message flag used by decode only.
// out_ch carries result characters; last_of_run marks the final result of
// an input transaction.
// Encode of A-Z, a-z or 0-9 gives its dots and dashes and a closing space,
// two to six results, one per cycle unless stalled; others give none.
// Decode gives at most one result, when a space or end-of-message closes a
// token that matches the table.
// The open token lives in a one-entry RAM with a registered read; the last
// write is forwarded, so decode items are taken every cycle unless stalled.
// The first result is shown in the cycle after its input is taken. An input
// holds the output register until its last result leaves; the next input is
// taken in the cycle its last result leaves, or at once if there is none.
// A stalled receiver holds the current result and stops input.
// Reset (rst, synchronous) empties the output register and clears the token.
// ----------------------------------------------------------------------------
module morse_encode_decode_unit (
  input  wire logic   clk,
  input  wire logic   rst,
  morse_in_if.sink    in_ch,
  morse_out_if.source out_ch
);
  import morse_pkg::*;

  tok_state_t        ram_rdata;
  tok_state_t        fwd_data;
  logic              fwd_hit;
  logic              state_valid;
  tok_state_t        cur_state;
  tok_state_t        upd_state;
  tok_state_t        wr_state;
  logic              ram_we;
  logic              in_acc;
  logic              closing;
  logic [7:0]        folded;
  code_t             enc_code;
  code_t             dec_code;
  logic              dec_emit;

  logic              busy;
  logic              enc_mode;
  count_t            idx;
  count_t            len;
  pattern_t          pat;
  logic [7:0]        dec_char;
  logic              last_beat;

  morse_ram #(
    .WIDTH (STATE_W),
    .DEPTH (1)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (1'b0),
    .wdata (wr_state),
    .raddr (1'b0),
    .rdata (ram_rdata)
  );

  // forward the write of the previous cycle past the registered read
  always_comb begin
    if (fwd_hit) begin
      cur_state = fwd_data;
    end else if (state_valid) begin
      cur_state = ram_rdata;
    end else begin
      cur_state = '0;
    end
  end

  always_comb begin
    upd_state = cur_state;
    closing   = 1'b0;
    if (in_ch.char_in == CH_SPACE) begin
      closing = 1'b1;
    end else begin
      if (in_ch.char_in == CH_DOT || in_ch.char_in == CH_DASH) begin
        if (32'(cur_state.count) >= MAX_SYMBOLS) begin
          upd_state.invalid = 1'b1;
        end else begin
          if (in_ch.char_in == CH_DASH && 32'(cur_state.count) < PATTERN_BITS) begin
            upd_state.pattern = cur_state.pattern | (pattern_t'(1) << cur_state.count);
          end
          upd_state.count = cur_state.count + 3'd1;
        end
      end else begin
        upd_state.invalid = 1'b1;
      end
      closing = in_ch.end_of_message;
    end
    wr_state = closing ? '0 : upd_state;
  end

  always_comb begin
    folded = in_ch.char_in;
    if (in_ch.char_in inside {[8'h61:8'h7A]}) begin
      folded = in_ch.char_in - CASE_DELTA;
    end
  end

  assign enc_code  = enc_lookup(folded);
  assign dec_code  = dec_lookup(upd_state.pattern, upd_state.count);
  assign dec_emit  = closing && upd_state.count != '0 && !upd_state.invalid && dec_code.hit;

  assign last_beat = enc_mode ? (idx == len) : 1'b1;
  assign in_ch.ready = !busy || (out_ch.ready && last_beat);
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign ram_we    = in_acc && in_ch.command == CMD_DECODE;

  assign out_ch.valid       = busy;
  assign out_ch.last_of_run = last_beat;

  always_comb begin
    if (!enc_mode) begin
      out_ch.char_out = dec_char;
    end else if (idx == len) begin
      out_ch.char_out = CH_SPACE;
    end else if (pat[idx]) begin
      out_ch.char_out = CH_DASH;
    end else begin
      out_ch.char_out = CH_DOT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit     <= 1'b0;
      state_valid <= 1'b0;
    end else begin
      fwd_hit <= ram_we;
      if (ram_we) begin
        state_valid <= 1'b1;
      end
    end
    if (ram_we) begin
      fwd_data <= wr_state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      if (in_acc) begin
        if (in_ch.command == CMD_ENCODE) begin
          busy <= enc_code.hit;
        end else begin
          busy <= dec_emit;
        end
      end else if (busy && out_ch.ready && last_beat) begin
        busy <= 1'b0;
      end
    end
    if (in_acc) begin
      enc_mode <= in_ch.command == CMD_ENCODE;
      idx      <= '0;
      len      <= enc_code.len;
      pat      <= enc_code.pattern;
      dec_char <= dec_code.ch;
    end else if (busy && out_ch.ready && !last_beat) begin
      idx <= idx + 3'd1;
    end
  end

  a_enc_first_symbol : assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_ch.command == CMD_ENCODE && enc_code.hit) |=>
      (out_ch.valid && (out_ch.char_out == CH_DOT || out_ch.char_out == CH_DASH)))
    else $error("encode did not start with a symbol");

  a_fwd_implies_valid : assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> state_valid)
    else $error("forwarded state without a written entry");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    32'(cur_state.count) <= MAX_SYMBOLS)
    else $error("token symbol count out of range");

  a_idx_bound : assert property (@(posedge clk) disable iff (rst)
    (busy && enc_mode) |-> (idx <= len))
    else $error("encode index past the closing space");

  a_drain : assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.last_of_run && !in_acc) |=> !out_ch.valid)
    else $error("result repeated after the last transaction of a run");

endmodule
`default_nettype wire
